// File: sv/pvm_pkg.sv
// shared types, register codes and fixed tables for the polyphonic sine voice mixer
// no dependencies; imported by polyphonic_sine_voice_mixer
package pvm_pkg;

	// register indexes, byte address 4*index
	localparam logic [2:0] REG_DECAY   = 3'd0;
	localparam logic [2:0] REG_FLOOR   = 3'd1;
	localparam logic [2:0] REG_GAIN    = 3'd2;
	localparam logic [2:0] REG_LOWEST  = 3'd3;
	localparam logic [2:0] REG_HIGHEST = 3'd4;

	// register reset values
	localparam logic [15:0] DECAY_RST   = 16'd65529;
	localparam logic [15:0] FLOOR_RST   = 16'd66;
	localparam logic [15:0] GAIN_RST    = 16'd3277;
	localparam logic [6:0]  LOWEST_RST  = 7'd21;
	localparam logic [6:0]  HIGHEST_RST = 7'd108;

	// request kinds and usb-midi code indexes
	localparam logic       REQ_EVENT    = 1'b0;
	localparam logic       REQ_TICK     = 1'b1;
	localparam logic [3:0] CIN_NOTE_OFF = 4'h8;
	localparam logic [3:0] CIN_NOTE_ON  = 4'h9;

	// q30 constants for the quarter wave series
	localparam longint unsigned Q30_ONE     = 64'd1 << 30;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TAYLOR_DIVS [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

	// q16 semitone ratios 2^(k/12)
	localparam longint unsigned SEMITONE_Q16 [12] = '{
		64'd65536, 64'd69433, 64'd73562, 64'd77936, 64'd82570, 64'd87480,
		64'd92682, 64'd98193, 64'd104032, 64'd110218, 64'd116772, 64'd123715
	};

	// gated level table, velocity/127 in q0.16
	typedef logic [15:0] lvl_tab_t [128];

	function automatic lvl_tab_t make_gated_levels();
		lvl_tab_t t;
		for (int v = 0; v < 128; v++) begin
			t[v] = 16'((v * 65535 + 63) / 127);
		end
		return t;
	endfunction

endpackage

// File: sv/polyphonic_sine_voice_mixer.sv
// top level of the polyphonic sine voice mixer: apb registers, voice memory,
// sequencer and the shared multiplier; depends on pvm_pkg
//
// a note-on or note-off word passes through accept, read and write back before the next
// is taken; a word with any other code index is dropped at accept while the block stays idle.
// a tick word walks V = highest_note-lowest_note+1 voices (clipped at NUM_NOTES), each
// through the read, level, mix and accumulate steps on the single shared multiplier and
// voice memory port, then the abs, low, high and output finishing steps; the next word is
// taken once the sample word is loaded into the output register; an untaken sample in the
// output register stalls the last step.
// reset restores register defaults; per-note valid bits make unwritten voices read as zero,
// so no clearing pass is needed and the block is ready as soon as reset is released.
module polyphonic_sine_voice_mixer #(
	parameter int NUM_NOTES       = 128,
	parameter int SAMPLE_RATE     = 44100,
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	// input word stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // cin[3:0], note[10:4], velocity[17:11], zero pad
	input  logic        s_tuser,   // req_type
	// output sample stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // sample_out[15:0]
	output logic        m_tuser,   // clipped
	// apb register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pvm_pkg::*;

	// widths derived from the parameters
	localparam int NI_W    = $clog2(NUM_NOTES);
	localparam int QUARTER = (1 << SINE_TABLE_BITS) >> 2;
	localparam int KW      = SINE_TABLE_BITS - 1;         // quarter table index, 0..QUARTER
	localparam int SUM_W   = 32 + $clog2(NUM_NOTES);      // exact voice sum
	localparam int LO_W    = 20;                          // low chunk of |sum| per multiply
	localparam int HI_W    = SUM_W - LO_W;
	localparam int TOT_W   = SUM_W + 16;
	localparam int RW      = TOT_W - 32;

	typedef logic [PHASE_BITS-1:0] step_tab_t [NUM_NOTES];
	typedef logic [14:0] qs_tab_t [QUARTER+1];

	// one voice memory word
	typedef struct packed {
		logic                  gate;
		logic [6:0]            vel;
		logic [PHASE_BITS-1:0] phase;
		logic [15:0]           level;
	} voice_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_EV_RD, ST_EV_WR, ST_RD, ST_LVL, ST_MIX, ST_ACC,
		ST_ABS, ST_LO, ST_HI, ST_OUT
	} state_t;

	// phase step per note, rounded half up, wrapped to PHASE_BITS
	function automatic step_tab_t make_steps();
		step_tab_t t;
		longint unsigned num;
		longint unsigned inc;
		longint unsigned sr;
		int d;
		int oct;
		int e;
		sr = longint'(SAMPLE_RATE);
		for (int n = 0; n < NUM_NOTES; n++) begin
			d = n + 3;
			oct = d / 12;
			num = 64'd440 * SEMITONE_Q16[d % 12];
			e = PHASE_BITS + oct - 22;
			if (e >= 0) begin
				inc = ((num << e) + sr / 2) / SAMPLE_RATE;
			end else begin
				// (num + den/2)/den with den = sr << -e, split into a divide and a shift
				inc = ((num + (sr << (-e - 1))) / SAMPLE_RATE) >> (-e);
			end
			t[n] = PHASE_BITS'(inc);
		end
		return t;
	endfunction

	// round(32767*sin(k*pi/2/QUARTER)) through the q30 series
	function automatic qs_tab_t make_quarter_sine();
		qs_tab_t t;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned tt;
		longint unsigned s;
		for (int k = 0; k <= QUARTER; k++) begin
			x = (longint'(k) * HALF_PI_Q30 + QUARTER / 2) >> (SINE_TABLE_BITS - 2);
			x2 = (x * x) >> 30;
			tt = Q30_ONE;
			for (int i = 0; i < 5; i++) begin
				tt = Q30_ONE - ((x2 * tt) >> 30) / TAYLOR_DIVS[i];
			end
			s = (x * tt) >> 30;
			t[k] = 15'((s * 64'd32767 + (64'd1 << 29)) >> 30);
		end
		return t;
	endfunction

	localparam lvl_tab_t  GATED_LVL = make_gated_levels();
	localparam step_tab_t STEP_TAB  = make_steps();
	localparam qs_tab_t   QS_TAB    = make_quarter_sine();

	// configuration registers
	logic [15:0] decay_q, floor_q, gain_q;
	logic [6:0]  lowest_q, highest_q;

	// sequencer and output register
	state_t      state_q;
	logic        out_valid_q;
	logic [15:0] out_data_q;
	logic        out_clip_q;

	// datapath registers
	logic [6:0]              n_q;          // note being worked on
	logic [6:0]              vel_q;
	logic                    on_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [37:0]      mul_q;
	logic                    act_q;
	logic [SUM_W-1:0]        mag_q;
	logic                    neg_q;
	logic [LO_W+15:0]        plo_q;
	logic [14:0]             qs_q;
	logic                    qneg_q;

	// voice memory with per-note valid bits
	voice_t                  voice_mem [NUM_NOTES];
	voice_t                  rd_q;
	logic                    rd_valid_q;
	logic [NUM_NOTES-1:0]    valid_q;

	logic                    cfg_we;
	logic                    s_acc;
	logic [3:0]              in_cin;
	logic [6:0]              in_note;
	logic [6:0]              in_vel;
	logic [NI_W-1:0]         n_idx;
	voice_t                  cur;
	voice_t                  wdata;
	logic                    mem_rd;
	logic                    mem_we;
	logic [15:0]             lvl_new;
	logic                    act;
	logic signed [15:0]      sine_s;
	logic signed [31:0]      vprod;
	logic signed [20:0]      mul_a;
	logic [15:0]             mul_b;
	logic [SINE_TABLE_BITS-1:0] sidx;
	logic [KW-1:0]           rr;
	logic [KW-1:0]           qk;
	logic [TOT_W-1:0]        total;
	logic [RW-1:0]           r;
	logic                    last_voice;
	logic                    start_ok;
	logic                    ev_ok;
	logic                    out_load;

	assign pready   = 1'b1;
	assign cfg_we   = psel & penable & pwrite & pready;
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid & s_tready;
	assign in_cin   = s_tdata[3:0];
	assign in_note  = s_tdata[10:4];
	assign in_vel   = s_tdata[17:11];
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_clip_q;

	assign n_idx = n_q[NI_W-1:0];
	assign cur   = rd_valid_q ? rd_q : '0;

	// register read back
	always_comb begin
		case (paddr[4:2])
			REG_DECAY:   prdata = {16'b0, decay_q};
			REG_FLOOR:   prdata = {16'b0, floor_q};
			REG_GAIN:    prdata = {16'b0, gain_q};
			REG_LOWEST:  prdata = {25'b0, lowest_q};
			REG_HIGHEST: prdata = {25'b0, highest_q};
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q   <= DECAY_RST;
			floor_q   <= FLOOR_RST;
			gain_q    <= GAIN_RST;
			lowest_q  <= LOWEST_RST;
			highest_q <= HIGHEST_RST;
		end else if (cfg_we) begin
			case (paddr[4:2])
				REG_DECAY:   decay_q   <= pwdata[15:0];
				REG_FLOOR:   floor_q   <= pwdata[15:0];
				REG_GAIN:    gain_q    <= pwdata[15:0];
				REG_LOWEST:  lowest_q  <= pwdata[6:0];
				REG_HIGHEST: highest_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// voice level: gated from velocity, else the decayed product from the last cycle
	assign lvl_new = cur.gate ? GATED_LVL[cur.vel] : mul_q[31:16];
	assign act     = lvl_new > floor_q;
	assign sine_s  = qneg_q ? -$signed({1'b0, qs_q}) : $signed({1'b0, qs_q});
	assign vprod   = mul_q[31:0];

	// quarter-wave index from the top phase bits, mirrored in odd quadrants
	assign sidx = cur.phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
	assign rr   = {1'b0, sidx[SINE_TABLE_BITS-3:0]};
	assign qk   = sidx[SINE_TABLE_BITS-2] ? (KW'(QUARTER) - rr) : rr;

	// memory port control
	assign mem_rd = (state_q == ST_EV_RD) || (state_q == ST_RD);
	assign mem_we = (state_q == ST_EV_WR) || (state_q == ST_MIX);

	always_comb begin
		wdata = cur;
		if (state_q == ST_EV_WR) begin
			wdata.vel  = vel_q;
			wdata.gate = on_q;
			if (on_q) begin
				wdata.phase = '0;
			end
		end else begin
			wdata.level = lvl_new;
			wdata.phase = act ? (cur.phase + STEP_TAB[n_idx]) : '0;
		end
	end

	// shared multiplier operands
	always_comb begin
		case (state_q)
			ST_LVL: begin
				mul_a = 21'(cur.level);
				mul_b = decay_q;
			end
			ST_MIX: begin
				mul_a = 21'(sine_s);
				mul_b = lvl_new;
			end
			ST_LO: begin
				mul_a = 21'(mag_q[LO_W-1:0]);
				mul_b = gain_q;
			end
			ST_HI: begin
				mul_a = 21'(mag_q[SUM_W-1:LO_W]);
				mul_b = gain_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// (|sum|*gain) >> 32 from the two partial products
	assign total = {mul_q[HI_W+15:0], {LO_W{1'b0}}} + TOT_W'(plo_q);
	assign r     = total[TOT_W-1:32];

	assign last_voice = (n_q == highest_q) || ({1'b0, n_q} == 8'(NUM_NOTES - 1));
	assign start_ok   = (lowest_q <= highest_q) && ({1'b0, lowest_q} < 8'(NUM_NOTES));
	assign ev_ok      = ((in_cin == CIN_NOTE_ON) || (in_cin == CIN_NOTE_OFF)) &&
	                    ({1'b0, in_note} < 8'(NUM_NOTES));

	// sample word goes to the output register once it is free
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_tready);

	// memory and table reads, registered
	always_ff @(posedge clk) begin
		if (mem_we) begin
			voice_mem[n_idx] <= wdata;
		end
		if (mem_rd) begin
			rd_q       <= voice_mem[n_idx];
			rd_valid_q <= valid_q[n_idx];
		end
		if (state_q == ST_LVL) begin
			qs_q   <= QS_TAB[qk];
			qneg_q <= sidx[SINE_TABLE_BITS-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (mem_we) begin
			valid_q[n_idx] <= 1'b1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		// high partial product is held while the sample waits for the output register
		if (state_q != ST_OUT) begin
			mul_q <= mul_a * $signed({1'b0, mul_b});
		end
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					n_q   <= (s_tuser == REQ_TICK) ? lowest_q : in_note;
					vel_q <= in_vel;
					on_q  <= (in_cin == CIN_NOTE_ON);
					sum_q <= '0;
				end
			end
			ST_MIX: act_q <= act;
			ST_ACC: begin
				if (act_q) begin
					sum_q <= sum_q + SUM_W'(vprod);
				end
				n_q <= n_q + 7'd1;
			end
			ST_ABS: begin
				mag_q <= sum_q[SUM_W-1] ? -sum_q : sum_q;
				neg_q <= sum_q[SUM_W-1];
			end
			ST_HI: plo_q <= mul_q[LO_W+15:0];
			default: ;
		endcase
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_clip_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (s_tuser == REQ_TICK) begin
							state_q <= start_ok ? ST_RD : ST_ABS;
						end else if (ev_ok) begin
							state_q <= ST_EV_RD;
						end
					end
				end
				ST_EV_RD: state_q <= ST_EV_WR;
				ST_EV_WR: state_q <= ST_IDLE;
				ST_RD:    state_q <= ST_LVL;
				ST_LVL:   state_q <= ST_MIX;
				ST_MIX:   state_q <= ST_ACC;
				ST_ACC:   state_q <= last_voice ? ST_ABS : ST_RD;
				ST_ABS:   state_q <= ST_LO;
				ST_LO:    state_q <= ST_HI;
				ST_HI:    state_q <= ST_OUT;
				ST_OUT: begin
					// hold here while an untaken sample still sits in the output register
					if (out_load) begin
						state_q <= ST_IDLE;
						if (!neg_q) begin
							out_clip_q <= (r > RW'(32767));
							out_data_q <= (r > RW'(32767)) ? 16'h7fff : r[15:0];
						end else begin
							out_clip_q <= (r > RW'(32768));
							out_data_q <= (r > RW'(32768)) ? 16'h8000 : 16'(-r);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a midi event never produces a sample word
	a_event_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_tuser == REQ_EVENT) |=> !$rose(m_tvalid))
		else $error("sample word raised after a midi event");

	// a clipped word carries a full-scale value
	a_clip_full_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == 16'h7fff || m_tdata == 16'h8000))
		else $error("clip flag without a saturated sample");

	// voice memory is only written inside the note range
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ({1'b0, n_q} < 8'(NUM_NOTES)))
		else $error("voice write beyond the note range");

endmodule

// File: test/polyphonic_sine_voice_mixer_tb.sv
// testbench for polyphonic_sine_voice_mixer: drives midi event and tick words,
// predicts every mixed sample with a scoreboard class and compares the output words
// depends on pvm_pkg and polyphonic_sine_voice_mixer
`timescale 1ns / 100ps

module polyphonic_sine_voice_mixer_tb;

	localparam logic [2:0] REG_UNUSED = 3'd6;   // no register here, writes are dropped
	localparam int SETTLE_CYCLES  = 16;
	localparam int ITEMS_PER_PHASE = 195;
	localparam int NUM_PHASES     = 10;

	typedef struct packed {
		logic signed [15:0] value;
		logic               clip;
	} mix_sample_t;

	// scoreboard: own copy of the voice state and registers, queue of predicted samples
	class mixer_scoreboard;
		logic [15:0]        decay_q16, floor_q16, gain_q16;
		logic [6:0]         low_key, high_key;
		bit                 key_gate [128];
		logic [6:0]         key_vel [128];
		logic [31:0]        key_phase [128];
		logic [15:0]        key_level [128];
		logic [31:0]        key_step [128];
		logic signed [15:0] sine_wave [1024];
		mix_sample_t        pending_samples [$];
		int                 errors;

		function new();
			longint unsigned semis [12];
			longint unsigned divs [5];
			longint unsigned x, x2, t, s, num, inc;
			int quarter [257];
			int d, oct, quad, r, v;
			semis = '{64'd65536, 64'd69433, 64'd73562, 64'd77936, 64'd82570, 64'd87480,
				64'd92682, 64'd98193, 64'd104032, 64'd110218, 64'd116772, 64'd123715};
			divs = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
			// quarter wave in q30 by a taylor series, rounded to q1.15
			for (int k = 0; k <= 256; k++) begin
				x = (64'(k) * 64'd1686629713 + 64'd128) / 64'd256;
				x2 = (x * x) >> 30;
				t = 64'd1 << 30;
				for (int i = 0; i < 5; i++) begin
					t = (64'd1 << 30) - ((x2 * t) >> 30) / divs[i];
				end
				s = (x * t) >> 30;
				quarter[k] = int'((s * 64'd32767 + (64'd1 << 29)) >> 30);
			end
			for (int i = 0; i < 1024; i++) begin
				quad = i / 256;
				r = i % 256;
				v = quad[0] ? quarter[256 - r] : quarter[r];
				sine_wave[i] = quad[1] ? 16'(-v) : 16'(v);
			end
			// phase increment per key: 440 hz * 2^((n-69)/12) * 2^32 / 44100
			for (int n = 0; n < 128; n++) begin
				d = n + 3;
				oct = d / 12;
				num = 64'd440 * semis[d % 12];
				inc = ((num << (10 + oct)) + 64'd22050) / 64'd44100;
				key_step[n] = inc[31:0];
				key_gate[n] = 1'b0;
				key_vel[n] = '0;
				key_phase[n] = '0;
				key_level[n] = '0;
			end
			decay_q16 = pvm_pkg::DECAY_RST;
			floor_q16 = pvm_pkg::FLOOR_RST;
			gain_q16 = pvm_pkg::GAIN_RST;
			low_key = pvm_pkg::LOWEST_RST;
			high_key = pvm_pkg::HIGHEST_RST;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				pvm_pkg::REG_DECAY:   decay_q16 = data[15:0];
				pvm_pkg::REG_FLOOR:   floor_q16 = data[15:0];
				pvm_pkg::REG_GAIN:    gain_q16 = data[15:0];
				pvm_pkg::REG_LOWEST:  low_key = data[6:0];
				pvm_pkg::REG_HIGHEST: high_key = data[6:0];
				default: ;
			endcase
		endfunction

		// walk the keys upward, refresh levels, sum the audible ones, scale and saturate
		function mix_sample_t mix_tick();
			longint          acc;
			longint unsigned mag, scaled;
			logic [31:0]     lvl;
			mix_sample_t     res;
			acc = 0;
			for (int n = low_key; n <= high_key; n++) begin
				if (key_gate[n])
					lvl = (32'(key_vel[n]) * 32'd65535 + 32'd63) / 32'd127;
				else
					lvl = (32'(key_level[n]) * 32'(decay_q16)) >> 16;
				key_level[n] = lvl[15:0];
				if (lvl > 32'(floor_q16)) begin
					acc += longint'(sine_wave[key_phase[n][31:22]]) * longint'(lvl);
					key_phase[n] = key_phase[n] + key_step[n];
				end else begin
					key_phase[n] = '0;
				end
			end
			mag = (acc < 0) ? 64'(-acc) : 64'(acc);
			scaled = (mag * 64'(gain_q16)) >> 32;
			res.clip = 1'b0;
			if (acc >= 0) begin
				if (scaled > 64'd32767) begin
					res.value = 16'sd32767;
					res.clip = 1'b1;
				end else begin
					res.value = scaled[15:0];
				end
			end else begin
				if (scaled > 64'd32768) begin
					res.value = -16'sd32768;
					res.clip = 1'b1;
				end else begin
					res.value = 16'(64'd0 - scaled);
				end
			end
			return res;
		endfunction

		function void note_word(logic req, logic [3:0] cin, logic [6:0] key, logic [6:0] vel);
			if (req == pvm_pkg::REQ_TICK) begin
				pending_samples.push_back(mix_tick());
			end else if (cin == pvm_pkg::CIN_NOTE_ON || cin == pvm_pkg::CIN_NOTE_OFF) begin
				key_vel[key] = vel;
				if (cin == pvm_pkg::CIN_NOTE_ON) begin
					key_gate[key] = 1'b1;
					key_phase[key] = '0;
				end else begin
					key_gate[key] = 1'b0;
				end
			end
		endfunction

		function void check_sample(logic [15:0] data, logic clip);
			mix_sample_t want;
			if (pending_samples.size() == 0) begin
				$display("%0t unexpected sample word: expected none, actual %0d clip %b",
					$time, $signed(data), clip);
				errors++;
				return;
			end
			want = pending_samples.pop_front();
			if (data !== want.value) begin
				$display("%0t sample_out mismatch: expected %0d, actual %0d",
					$time, want.value, $signed(data));
				errors++;
			end
			if (clip !== want.clip) begin
				$display("%0t clipped mismatch: expected %b, actual %b", $time, want.clip, clip);
				errors++;
			end
		endfunction

		function int pending();
			return pending_samples.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // cin[3:0], note[10:4], velocity[17:11], zero pad
	logic        s_tuser = 1'b0; // req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // sample_out[15:0]
	logic        m_tuser;        // clipped
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	mixer_scoreboard sb = new();

	bit       tx_steady = 1'b0;   // no gaps on the input side
	bit       rx_steady = 1'b0;   // no stalls on the output side
	logic [6:0] cur_lo = pvm_pkg::LOWEST_RST;
	logic [6:0] cur_hi = pvm_pkg::HIGHEST_RST;

	polyphonic_sine_voice_mixer i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly no gap, some short ones, a few long ones
	function automatic int pick_gap(bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// key inside the rendered window most of the time
	function automatic logic [6:0] pick_key();
		if (cur_lo > cur_hi || $urandom_range(0, 9) == 0)
			return 7'($urandom);
		return 7'($urandom_range(cur_lo, cur_hi));
	endfunction

	function automatic logic [6:0] pick_velocity();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 7'd127;
		if (r < 13)
			return 7'd0;
		return 7'($urandom);
	endfunction

	// one input word; valid stays high into the next call when there is no gap
	task automatic push_word(input logic req, input logic [3:0] cin, input logic [6:0] key,
		input logic [6:0] vel);
		int gap;
		gap = pick_gap(tx_steady);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {6'd0, vel, key, cin};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_word(req, cin, key, vel);
	endtask

	// tick words carry random bits in the unused fields
	task automatic send_tick();
		push_word(pvm_pkg::REQ_TICK, 4'($urandom), 7'($urandom), 7'($urandom));
	endtask

	task automatic send_event(input logic [3:0] cin, input logic [6:0] key, input logic [6:0] vel);
		push_word(pvm_pkg::REQ_EVENT, cin, key, vel);
	endtask

	// stop sending, wait for every predicted sample, then let a pending event finish
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, data);
	endtask

	// register settings per phase, extremes first, then a typical set, then random ones
	task automatic configure(input int phase);
		logic [15:0] dcy, flr, gn;
		logic [6:0]  lo, hi;
		case (phase)
			1: begin
				dcy = 16'hFFFF; flr = 16'd0; gn = 16'hFFFF; lo = 7'd0; hi = 7'd127;
			end
			2: begin
				dcy = 16'd0; flr = 16'hFFFF; gn = 16'd1; lo = 7'd40; hi = 7'd52;
			end
			3: begin
				dcy = 16'd65000; flr = 16'd100; gn = 16'hFFFF; lo = 7'd100; hi = 7'd30;
			end
			4: begin
				dcy = 16'd60000; flr = 16'd300; gn = 16'd3277; lo = 7'd48; hi = 7'd72;
			end
			default: begin
				dcy = 16'($urandom_range(40000, 65535));
				flr = 16'($urandom_range(0, 3000));
				gn = 16'($urandom);
				lo = 7'($urandom_range(0, 110));
				hi = lo + 7'($urandom_range(0, 17));
			end
		endcase
		// upper data bits are junk, the block must drop them
		apb_write(pvm_pkg::REG_DECAY, {16'($urandom), dcy});
		apb_write(pvm_pkg::REG_FLOOR, {16'($urandom), flr});
		apb_write(pvm_pkg::REG_GAIN, {16'($urandom), gn});
		apb_write(pvm_pkg::REG_LOWEST, {25'($urandom), lo});
		apb_write(pvm_pkg::REG_HIGHEST, {25'($urandom), hi});
		if (phase == 3)
			apb_write(REG_UNUSED, $urandom);
		cur_lo = lo;
		cur_hi = hi;
	endtask

	// output side: check each accepted sample word, stall at random
	initial begin
		int stall;
		stall = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_sample(m_tdata, m_tuser);
			if (rx_steady) begin
				m_tready <= 1'b1;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				stall = pick_gap(1'b0);
			end
		end
	end

	initial begin
		#60_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int done, r;
		logic [3:0] cin;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at the reset register values
		send_tick();                                   // nothing playing
		send_event(pvm_pkg::CIN_NOTE_ON, 7'd69, 7'd127);
		send_tick();
		send_tick();
		send_event(pvm_pkg::CIN_NOTE_ON, 7'd21, 7'd0);   // gated at level zero
		send_tick();
		send_event(4'h7, 7'd60, 7'd100);               // other code indexes are ignored
		send_event(4'hF, 7'd127, 7'd127);
		send_event(4'h0, 7'd0, 7'd0);
		send_event(pvm_pkg::CIN_NOTE_ON, 7'd127, 7'd1);  // above the rendered window
		send_event(pvm_pkg::CIN_NOTE_ON, 7'd0, 7'd64);   // below the rendered window
		send_tick();
		send_event(pvm_pkg::CIN_NOTE_OFF, 7'd69, 7'd127); // release starts decaying
		send_tick();
		send_tick();
		send_event(pvm_pkg::CIN_NOTE_OFF, 7'd21, 7'd0);  // silent release
		send_tick();
		send_event(pvm_pkg::CIN_NOTE_ON, 7'd108, 7'd100);
		send_event(pvm_pkg::CIN_NOTE_ON, 7'd60, 7'd90);
		send_tick();
		send_tick();

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase > 0) begin
				drain();
				configure(phase);
			end
			tx_steady = (phase == 4);
			rx_steady = (phase == 4);
			done = 0;
			while (done < ITEMS_PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 38) begin
					send_event(pvm_pkg::CIN_NOTE_ON, pick_key(), pick_velocity());
					done++;
				end else if (r < 54) begin
					send_event(pvm_pkg::CIN_NOTE_OFF, pick_key(), 7'($urandom));
					done++;
				end else if (r < 93) begin
					send_tick();
					done++;
				end else if (r < 99) begin
					// noise: any code index, any key
					cin = 4'($urandom);
					send_event(cin, 7'($urandom), 7'($urandom));
					done++;
				end else begin
					drain();   // hold input until the output side catches up
				end
			end
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;

		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: polyphonic_sine_voice_mixer.f
sv/pvm_pkg.sv
sv/polyphonic_sine_voice_mixer.sv
test/polyphonic_sine_voice_mixer_tb.sv
